// ===== hw/rtl/atfrd_pkg.sv =====
// Package for the AT final result detector: character codes, token tables,
// line kind codes and the result struct. No dependencies.
package atfrd_pkg;

  localparam int unsigned PosW      = 4;
  localparam int unsigned KindW     = 3;
  localparam int unsigned TokCount  = 4;
  localparam int unsigned PrefixLen = 11;

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharSpace = 8'h20;

  localparam logic [PosW-1:0] PosMax     = '1;
  localparam logic [PosW-1:0] PrefixLast = PosW'(PrefixLen - 1);

  typedef enum logic [KindW-1:0] {
    KIND_NONE  = 3'd0,
    KIND_OK    = 3'd1,
    KIND_ERROR = 3'd2,
    KIND_CME   = 3'd3,
    KIND_CMS   = 3'd4
  } line_kind_e;

  typedef enum logic [1:0] {
    TOK_OK    = 2'd0,
    TOK_ERROR = 2'd1,
    TOK_CME   = 2'd2,
    TOK_CMS   = 2'd3
  } tok_e;

  localparam logic [PosW-1:0] TokLen [TokCount] = '{4'd2, 4'd5, 4'd11, 4'd11};

  localparam logic [7:0] TokChars [TokCount][16] = '{
    '{8'h4F, 8'h4B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2B, 8'h43, 8'h4D, 8'h45, 8'h20, 8'h45, 8'h52, 8'h52,
      8'h4F, 8'h52, 8'h3A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2B, 8'h43, 8'h4D, 8'h53, 8'h20, 8'h45, 8'h52, 8'h52,
      8'h4F, 8'h52, 8'h3A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  typedef struct packed {
    line_kind_e line_kind;
    logic       final_found;
    logic       error_found;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CharSpace) || (c == CharTab);
  endfunction

endpackage

// ===== hw/rtl/atfrd_matcher.sv =====
// Line matcher: keeps the per-line match state and the sticky flags, and
// classifies the line closed by each word. Depends on atfrd_pkg.
module atfrd_matcher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         text_byte_i,
  input  logic               end_of_response_i,
  output atfrd_pkg::result_t result_o
);

  logic                            started_q, started_d;
  logic [atfrd_pkg::PosW-1:0]      pos_q, pos_d;
  logic [atfrd_pkg::PosW-1:0]      trim_q, trim_d;
  logic [atfrd_pkg::TokCount-1:0]  alive_q, alive_d;
  logic [1:0]                      prefix_q, prefix_d;
  logic                            final_q, final_d;
  logic                            error_q, error_d;

  logic                            close_line;
  logic                            blank;
  logic [atfrd_pkg::PosW-1:0]      pos_inc;
  logic [atfrd_pkg::TokCount-1:0]  alive_chk;
  atfrd_pkg::line_kind_e           kind;
  logic                            final_out;
  logic                            error_out;

  assign close_line = end_of_response_i || (text_byte_i == atfrd_pkg::CharCr) ||
                      (text_byte_i == atfrd_pkg::CharLf);
  assign blank      = atfrd_pkg::is_blank(text_byte_i);
  assign pos_inc    = (pos_q == atfrd_pkg::PosMax) ? pos_q : pos_q + 1'b1;

  always_comb begin
    for (int t = 0; t < atfrd_pkg::TokCount; t++) begin
      alive_chk[t] = alive_q[t] &&
                     !((pos_q < atfrd_pkg::TokLen[t]) &&
                       (atfrd_pkg::TokChars[t][pos_q] != text_byte_i));
    end
  end

  always_comb begin
    kind = atfrd_pkg::KIND_NONE;
    if (started_q) begin
      if (alive_q[atfrd_pkg::TOK_OK] && (trim_q == atfrd_pkg::TokLen[atfrd_pkg::TOK_OK])) begin
        kind = atfrd_pkg::KIND_OK;
      end else if (alive_q[atfrd_pkg::TOK_ERROR] &&
                   (trim_q == atfrd_pkg::TokLen[atfrd_pkg::TOK_ERROR])) begin
        kind = atfrd_pkg::KIND_ERROR;
      end else if (prefix_q[0]) begin
        kind = atfrd_pkg::KIND_CME;
      end else if (prefix_q[1]) begin
        kind = atfrd_pkg::KIND_CMS;
      end
    end
  end

  always_comb begin
    final_out = final_q;
    error_out = error_q;
    if (close_line && (kind != atfrd_pkg::KIND_NONE)) begin
      final_out = 1'b1;
      if (kind != atfrd_pkg::KIND_OK) begin
        error_out = 1'b1;
      end
    end
  end

  always_comb begin
    started_d = started_q;
    pos_d     = pos_q;
    trim_d    = trim_q;
    alive_d   = alive_q;
    prefix_d  = prefix_q;
    final_d   = final_out;
    error_d   = error_out;
    if (close_line) begin
      started_d = 1'b0;
      pos_d     = '0;
      trim_d    = '0;
      alive_d   = '1;
      prefix_d  = '0;
      if (end_of_response_i) begin
        final_d = 1'b0;
        error_d = 1'b0;
      end
    end else if (started_q || !blank) begin
      started_d = 1'b1;
      alive_d   = alive_chk;
      pos_d     = pos_inc;
      if (!blank) begin
        trim_d = pos_inc;
      end
      if (pos_q == atfrd_pkg::PrefixLast) begin
        prefix_d = prefix_q | {alive_chk[atfrd_pkg::TOK_CMS], alive_chk[atfrd_pkg::TOK_CME]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      pos_q     <= '0;
      trim_q    <= '0;
      alive_q   <= '1;
      prefix_q  <= '0;
      final_q   <= 1'b0;
      error_q   <= 1'b0;
    end else if (step_i) begin
      started_q <= started_d;
      pos_q     <= pos_d;
      trim_q    <= trim_d;
      alive_q   <= alive_d;
      prefix_q  <= prefix_d;
      final_q   <= final_d;
      error_q   <= error_d;
    end
  end

  assign result_o.line_kind   = close_line ? kind : atfrd_pkg::KIND_NONE;
  assign result_o.final_found = final_out;
  assign result_o.error_found = error_out;

endmodule

// ===== hw/rtl/atfrd_out_reg.sv =====
// Result register: holds one result word for the output side and lets the
// input side continue while the result is being taken. Depends on atfrd_pkg.
module atfrd_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  atfrd_pkg::result_t result_i,
  input  logic               ready_i,
  output logic               free_o,
  output logic               valid_o,
  output atfrd_pkg::result_t result_o
);

  logic               valid_q, valid_d;
  atfrd_pkg::result_t data_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

endmodule

// ===== hw/rtl/at_final_result_detector.sv =====
// Top level of the AT final result detector: line matcher and result register.
// Depends on atfrd_pkg, atfrd_matcher and atfrd_out_reg.
//
// Takes one response byte per cycle while the result register is free, and
// returns one result word per byte, registered in the cycle after the byte
// is taken; the throughput is one byte per clock, limited only by the single
// result register, which is reloaded in the same cycle that its word is
// taken. A word with tlast set ends the response: its byte is ignored, the
// pending line is classified and the sticky flags clear after its result.
module at_final_result_detector (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] text_byte
  input  logic       s_axis_tlast_i,  // end_of_response
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o   // [2:0] line_kind, [3] final_found,
                                      // [4] error_found, [7:5] zero
);

  logic               accept;
  logic               free;
  atfrd_pkg::result_t step_result;
  atfrd_pkg::result_t out_result;

  assign accept          = s_axis_tvalid_i && free;
  assign s_axis_tready_o = free;

  atfrd_matcher u_matcher (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (accept),
    .text_byte_i       (s_axis_tdata_i),
    .end_of_response_i (s_axis_tlast_i),
    .result_o          (step_result)
  );

  atfrd_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .result_i (step_result),
    .ready_i  (m_axis_tready_i),
    .free_o   (free),
    .valid_o  (m_axis_tvalid_o),
    .result_o (out_result)
  );

  assign m_axis_tdata_o = {3'b000, out_result.error_found, out_result.final_found,
                           out_result.line_kind};

endmodule

// ===== hw/rtl/atfrd_checker.sv =====
// Port-level checker for the AT final result detector, bound to the top
// level. Depends on atfrd_pkg and at_final_result_detector.
module atfrd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  logic [2:0] kind;

  assign kind = m_axis_tdata_o[2:0];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Result word changed while stalled.");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> kind <= atfrd_pkg::KIND_CMS)
    else $error("Line kind out of range.");

  a_error_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[4] |-> m_axis_tdata_o[3])
    else $error("Error flag set without final flag.");

  a_kind_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (kind != atfrd_pkg::KIND_NONE) |-> m_axis_tdata_o[3])
    else $error("Final line reported without final flag.");

  a_kind_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ((kind == atfrd_pkg::KIND_ERROR) || (kind == atfrd_pkg::KIND_CME) ||
                        (kind == atfrd_pkg::KIND_CMS)) |-> m_axis_tdata_o[4])
    else $error("Error line reported without error flag.");

endmodule

bind at_final_result_detector atfrd_checker u_atfrd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== tb/tb_at_final_result_detector.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for at_final_result_detector: streams response bytes and
// compares every result word with a local line classifier. Depends on atfrd_pkg and at_final_result_detector.
module tb_at_final_result_detector;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;
  logic       s_axis_tlast_i = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;

  string tok_text [atfrd_pkg::TokCount] = '{"OK", "ERROR", "+CME ERROR:", "+CMS ERROR:"};

  logic                       line_started = 1'b0;
  logic [atfrd_pkg::PosW-1:0] line_pos     = '0;
  logic [atfrd_pkg::PosW-1:0] trim_len     = '0;
  logic [3:0]                 tok_alive    = '1;
  logic [1:0]                 prefix_done  = '0;
  logic                       final_flag   = 1'b0;
  logic                       error_flag   = 1'b0;

  atfrd_pkg::result_t expected_results [$];
  atfrd_pkg::result_t want;
  atfrd_pkg::result_t got;
  int      error_count   = 0;
  int      words_sent    = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      stall_cycles  = 0;
  logic    stall_req     = 1'b0;
  logic    stall_req_q   = 1'b0;

  at_final_result_detector u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb_at_final_result_detector: errors");
    $finish;
  end

  // Classifies the line as bytes arrive and returns the word the block must produce.
  function automatic atfrd_pkg::result_t predict_line_result(input logic [7:0] c,
                                                              input logic eor);
    atfrd_pkg::result_t         r;
    logic [atfrd_pkg::PosW-1:0] p;
    r.line_kind = atfrd_pkg::KIND_NONE;
    if (eor || c == atfrd_pkg::CharCr || c == atfrd_pkg::CharLf) begin
      if (line_started) begin
        if (tok_alive[atfrd_pkg::TOK_OK] && trim_len == 4'd2) begin
          r.line_kind = atfrd_pkg::KIND_OK;
        end else if (tok_alive[atfrd_pkg::TOK_ERROR] && trim_len == 4'd5) begin
          r.line_kind = atfrd_pkg::KIND_ERROR;
        end else if (prefix_done[0]) begin
          r.line_kind = atfrd_pkg::KIND_CME;
        end else if (prefix_done[1]) begin
          r.line_kind = atfrd_pkg::KIND_CMS;
        end
      end
      if (r.line_kind != atfrd_pkg::KIND_NONE) begin
        final_flag = 1'b1;
        if (r.line_kind != atfrd_pkg::KIND_OK) begin
          error_flag = 1'b1;
        end
      end
      line_started = 1'b0;
      line_pos     = '0;
      trim_len     = '0;
      tok_alive    = '1;
      prefix_done  = '0;
    end else if (line_started || !(c == atfrd_pkg::CharSpace || c == atfrd_pkg::CharTab)) begin
      line_started = 1'b1;
      p = line_pos;
      for (int t = 0; t < atfrd_pkg::TokCount; t++) begin
        if (p < tok_text[t].len() && tok_text[t][p] != c) begin
          tok_alive[t] = 1'b0;
        end
      end
      if (p == atfrd_pkg::PrefixLast) begin
        prefix_done[0] = prefix_done[0] | tok_alive[atfrd_pkg::TOK_CME];
        prefix_done[1] = prefix_done[1] | tok_alive[atfrd_pkg::TOK_CMS];
      end
      if (!(c == atfrd_pkg::CharSpace || c == atfrd_pkg::CharTab)) begin
        trim_len = (p == atfrd_pkg::PosMax) ? atfrd_pkg::PosMax : p + 1'b1;
      end
      line_pos = (p == atfrd_pkg::PosMax) ? atfrd_pkg::PosMax : p + 1'b1;
    end
    r.final_found = final_flag;
    r.error_found = error_flag;
    if (eor) begin
      final_flag = 1'b0;
      error_flag = 1'b0;
    end
    return r;
  endfunction

  // Valid stays high after a word is taken, unless an idle gap is drawn, so that the next word can follow at once.
  task automatic send_word(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_results.push_back(predict_line_result(b, last));
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i], 1'b0);
    end
  endtask

  task automatic send_blanks();
    repeat ($urandom_range(0, 3)) begin
      send_word($urandom_range(1) ? atfrd_pkg::CharSpace : atfrd_pkg::CharTab, 1'b0);
    end
  endtask

  task automatic send_random_line();
    int t;
    int n;
    int m;
    send_blanks();
    t = $urandom_range(3);
    n = tok_text[t].len();
    case ($urandom_range(7)) inside
      0, 1: begin
        send_text(tok_text[$urandom_range(1)]);
      end
      2, 3: begin
        send_text(tok_text[$urandom_range(2, 3)]);
        repeat ($urandom_range(0, 6)) send_word(8'($urandom_range(255)), 1'b0);
      end
      4: begin
        m = $urandom_range(n - 1);
        for (int i = 0; i < n; i++) begin
          send_word(i == m ? tok_text[t][i] ^ (8'h01 << $urandom_range(7)) : tok_text[t][i],
                    1'b0);
        end
      end
      5: begin
        m = $urandom_range(1, n + 1);
        for (int i = 0; i < m; i++) begin
          send_word(i < n ? tok_text[t][i] : 8'($urandom_range(33, 126)), 1'b0);
        end
      end
      default: begin
        repeat ($urandom_range(0, 20)) send_word(8'($urandom_range(255)), 1'b0);
      end
    endcase
    send_blanks();
    case ($urandom_range(7)) inside
      0, 1, 2: begin
        send_word(atfrd_pkg::CharCr, 1'b0);
        send_word(atfrd_pkg::CharLf, 1'b0);
      end
      3: send_word(atfrd_pkg::CharCr, 1'b0);
      4: send_word(atfrd_pkg::CharLf, 1'b0);
      5, 6: send_word(8'($urandom_range(255)), 1'b1);
      default: ;
    endcase
  endtask

  task automatic test_trimmed_ok_line();
    send_word(atfrd_pkg::CharTab, 1'b0);
    send_text("OK ");
    send_word(atfrd_pkg::CharCr, 1'b0);
    send_word(atfrd_pkg::CharLf, 1'b0);
  endtask

  task automatic test_error_end_of_response();
    send_text("ERROR");
    send_word(8'hFF, 1'b1);
  endtask

  task automatic test_prefix_with_tail();
    send_text(tok_text[atfrd_pkg::TOK_CMS]);
    send_word(8'h00, 1'b0);
    send_word(atfrd_pkg::CharLf, 1'b0);
  endtask

  task automatic test_random_responses(input int word_count);
    int stop_at;
    stop_at = words_sent + word_count;
    while (words_sent < stop_at) begin
      send_random_line();
    end
  endtask

  // The receiver holds off while lines keep coming, so the input side must stall.
  task automatic test_receiver_stall();
    stall_req = 1'b1;
    repeat (6) send_random_line();
  endtask

  always @(negedge clk_i) begin
    stall_req_q <= stall_req;
    if (stall_req && !stall_req_q) begin
      m_axis_tready_i <= 1'b0;
      stall_cycles    <= 299;
    end else if (stall_cycles != 0) begin
      m_axis_tready_i <= 1'b0;
      stall_cycles    <= stall_cycles - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h",
                 $time, m_axis_tdata_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        got  = {m_axis_tdata_o[2:0], m_axis_tdata_o[3], m_axis_tdata_o[4]};
        if (got !== want) begin
          $display("%0t: mismatch, expected kind %0d final %b error %b, actual %0d %b %b",
                   $time, want.line_kind, want.final_found, want.error_found,
                   got.line_kind, got.final_found, got.error_found);
          error_count++;
        end
      end
    end
  end

  initial begin
    int drain_wait;
    drain_wait = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = 33;
    recv_idle_pct = 66;
    test_trimmed_ok_line();
    test_error_end_of_response();
    test_prefix_with_tail();
    test_random_responses(560);
    send_idle_pct = 66;
    recv_idle_pct = 33;
    test_random_responses(560);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_receiver_stall();
    test_random_responses(560);
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0 && drain_wait < 20000) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected result words never arrived", $time,
               expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb_at_final_result_detector: clean");
    end else begin
      $display("tb_at_final_result_detector: errors");
    end
    $finish;
  end

endmodule
